FILE: hw/rtl/hourly_ema_trend_regime_gate_top_defines.svh
// Assertion helpers shared by the gate's RTL.
// Each use must sit where clk and rst are visible.
`ifndef HOURLY_EMA_TREND_REGIME_GATE_TOP_DEFINES_SVH
`define HOURLY_EMA_TREND_REGIME_GATE_TOP_DEFINES_SVH

// Same-cycle implication.
`define HETRG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HETRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hetrg_pkg.sv
package hetrg_pkg;

  localparam int DEF_HISTORY_DEPTH = 128;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int GAIN_BITS   = 16;
  localparam int PRICE_W     = 32;
  localparam int TIME_W      = 40;
  localparam int SECONDS_W   = 17;
  localparam int PERIOD_W    = 10;
  localparam int PERSIST_W   = 7;
  localparam int COUNT_W     = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int STEP_W      = $clog2(TIME_W);

  localparam logic [GAIN_BITS-1:0] RST_SLOW_GAIN       = 16'd652;
  localparam logic [GAIN_BITS-1:0] RST_FAST_GAIN       = 16'd2570;
  localparam logic [PERIOD_W-1:0]  RST_SLOW_PERIOD     = 10'd200;
  localparam logic [PERSIST_W-1:0] RST_PERSIST_BUCKETS = 7'd100;
  localparam logic [SECONDS_W-1:0] RST_BUCKET_SECONDS  = 17'd3600;

  typedef struct packed {
    logic [TIME_W-1:0]  sample_time;
    logic [PRICE_W-1:0] close_price;
  } sample_t;

  typedef struct packed {
    logic long_block;
    logic short_block;
    logic is_warm;
    logic bucket_closed;
  } result_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLOW_GAIN       = 3'd0,
    CFG_FAST_GAIN       = 3'd1,
    CFG_SLOW_PERIOD     = 3'd2,
    CFG_PERSIST_BUCKETS = 3'd3,
    CFG_BUCKET_SECONDS  = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SEED,
    ST_SLOW_START,
    ST_SLOW_MUL,
    ST_SLOW_RND,
    ST_SLOW_APPLY,
    ST_FAST_START,
    ST_FAST_MUL,
    ST_FAST_RND,
    ST_FAST_APPLY,
    ST_HIST_WR,
    ST_HIST_RD,
    ST_EVAL,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic check;
    logic seed;
    logic mul_start;
    logic mul_step;
    logic mul_round;
    logic mul_apply;
    logic sel_fast;
    logic hist_write;
    logic hist_read;
    logic eval;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic fold_now;
    logic seeded;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: hw/rtl/hourly_ema_trend_regime_gate_top.sv
// Hourly dual-average trend regime gate. Each request carries one minute
// sample (timestamp in seconds, close in ticks) and returns exactly one result:
// the bear flag as long_block, the bull flag as short_block, the warm status,
// and whether this sample closed a bucket. Samples fall into buckets of
// bucket_seconds (zero acts as one); when the bucket index changes, the last
// close of the finished bucket is folded into a slow and a fast exponential
// average (Q32.FRACTION_BITS, gains Q0.16), and the slow average is pushed into
// a HISTORY_DEPTH-entry ring used for the slope test. The trailing partial
// bucket is never folded. One sample is worked at a time: a new sample is
// taken only after the last one's result has been written, which waits
// while the result side stalls. The bucket index is formed by the 40-step
// restoring divider; both averages share the 16-step serial multiplier.
// The history ring needs no clearing pass; a fill count keeps unwritten
// entries from being used. Configuration writes are always taken and must
// only be issued while no sample is in flight.
module hourly_ema_trend_regime_gate_top import hetrg_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // sample requests
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  // result requests
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Registers are held stable between samples, so accept writes every cycle.
  assign cfg_ready = 1'b1;

  // Controller: sequences divide, fold, history access and result write.
  hetrg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Datapath: registers, divider, multiplier, averages, history ring and
  // the output register that decouples the result side.
  hetrg_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

FILE: hw/rtl/hetrg_ctrl.sv
`include "hourly_ema_trend_regime_gate_top_defines.svh"

module hetrg_ctrl import hetrg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (sample_valid) state_next = ST_DIV;
      ST_DIV:        if (stat.div_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!stat.fold_now) begin
          state_next = ST_EMIT;
        end else if (stat.seeded) begin
          state_next = ST_SLOW_START;
        end else begin
          state_next = ST_SEED;
        end
      end
      ST_SEED:       state_next = ST_HIST_WR;
      ST_SLOW_START: state_next = ST_SLOW_MUL;
      ST_SLOW_MUL:   if (stat.mul_done) state_next = ST_SLOW_RND;
      ST_SLOW_RND:   state_next = ST_SLOW_APPLY;
      ST_SLOW_APPLY: state_next = ST_FAST_START;
      ST_FAST_START: state_next = ST_FAST_MUL;
      ST_FAST_MUL:   if (stat.mul_done) state_next = ST_FAST_RND;
      ST_FAST_RND:   state_next = ST_FAST_APPLY;
      ST_FAST_APPLY: state_next = ST_HIST_WR;
      ST_HIST_WR:    state_next = ST_HIST_RD;
      ST_HIST_RD:    state_next = ST_EVAL;
      ST_EVAL:       state_next = ST_EMIT;
      ST_EMIT:       if (stat.out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.load     = sample_valid;
      end
      ST_DIV:        cmd.div_step = 1'b1;
      ST_CHECK:      cmd.check = 1'b1;
      ST_SEED:       cmd.seed = 1'b1;
      ST_SLOW_START: cmd.mul_start = 1'b1;
      ST_SLOW_MUL:   cmd.mul_step = 1'b1;
      ST_SLOW_RND:   cmd.mul_round = 1'b1;
      ST_SLOW_APPLY: cmd.mul_apply = 1'b1;
      ST_FAST_START: begin
        cmd.mul_start = 1'b1;
        cmd.sel_fast  = 1'b1;
      end
      ST_FAST_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.sel_fast = 1'b1;
      end
      ST_FAST_RND: begin
        cmd.mul_round = 1'b1;
        cmd.sel_fast  = 1'b1;
      end
      ST_FAST_APPLY: begin
        cmd.mul_apply = 1'b1;
        cmd.sel_fast  = 1'b1;
      end
      ST_HIST_WR:    cmd.hist_write = 1'b1;
      ST_HIST_RD:    cmd.hist_read = 1'b1;
      ST_EVAL:       cmd.eval = 1'b1;
      ST_EMIT:       cmd.emit = stat.out_free;
      default:       cmd = '0;
    endcase
  end

  `HETRG_ASSERT_NEXT(a_accept_starts_div, sample_valid && !sample_stall, state == ST_DIV, "accepted request did not start the divider")
  `HETRG_ASSERT_IMPL(a_emit_needs_room, cmd.emit, stat.out_free, "result written over a pending result")

endmodule

FILE: hw/rtl/hetrg_dp.sv
`include "hourly_ema_trend_regime_gate_top_defines.svh"

module hetrg_dp import hetrg_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  sample_t                sample,
  output result_t                result,
  output logic                   result_valid,
  input  logic                   result_stall,
  input  ctrl_cmd_t              cmd,
  output ctrl_stat_t             stat
);

  localparam int AVG_W  = PRICE_W + FRACTION_BITS;
  localparam int ACC_W  = AVG_W + GAIN_BITS;
  localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CALC_W = PTR_W + PERSIST_W + 1;
  localparam int CMP_W  = FILL_W + PERSIST_W + 1;
  localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'((64'd1 << GAIN_BITS) - 64'd1);

  // configuration
  logic [GAIN_BITS-1:0] slow_gain, fast_gain;
  logic [PERIOD_W-1:0]  slow_period;
  logic [PERSIST_W-1:0] persist_buckets;
  logic [SECONDS_W-1:0] bucket_seconds;

  // divider
  logic [TIME_W-1:0]    div_q;
  logic [SECONDS_W-1:0] div_r, div_d;
  logic [SECONDS_W:0]   div_shift, div_trial;
  logic                 div_ge;
  logic [STEP_W-1:0]    step_cnt;

  // open bucket
  logic [PRICE_W-1:0] close_in, bucket_close;
  logic [TIME_W-1:0]  open_bucket;
  logic               bucket_open, closed_flag;

  // averages and shared multiplier
  logic [AVG_W-1:0]     slow_avg, fast_avg, cfix, sel_avg, mag, delta;
  logic                 seeded, mul_down;
  logic [ACC_W-1:0]     acc;
  logic [GAIN_BITS-1:0] gain_sh;

  // slow-average history
  logic [AVG_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [AVG_W-1:0]   hist_rd;
  logic [PTR_W-1:0]   hist_wp, rd_idx;
  logic [FILL_W-1:0]  hist_fill;
  logic [CALC_W-1:0]  cur_ext, back_ext, back_diff;

  logic [COUNT_W-1:0] bucket_count, warm_level;
  logic               bear_flag, bull_flag, warm, fill_ok;

  assign cfix      = {bucket_close, {FRACTION_BITS{1'b0}}};
  assign sel_avg   = cmd.sel_fast ? fast_avg : slow_avg;
  assign delta     = acc[ACC_W-1:GAIN_BITS];
  assign div_shift = {div_r, div_q[TIME_W-1]};
  assign div_ge    = div_shift >= {1'b0, div_d};
  assign div_trial = div_shift - {1'b0, div_d};

  // Look back persist_buckets entries from the write slot; only meaningful
  // when the lookback fits inside the ring, which the fill test guarantees.
  assign cur_ext   = CALC_W'(hist_wp);
  assign back_ext  = CALC_W'(persist_buckets);
  assign back_diff = (cur_ext >= back_ext) ? (cur_ext - back_ext)
                                           : (cur_ext + CALC_W'(HISTORY_DEPTH) - back_ext);

  assign warm_level = COUNT_W'(slow_period) + COUNT_W'(persist_buckets);
  assign warm       = bucket_count >= warm_level;
  assign fill_ok    = CMP_W'(hist_fill) >= (CMP_W'(persist_buckets) + CMP_W'(1));

  assign stat.div_done = step_cnt == STEP_W'(TIME_W - 1);
  assign stat.mul_done = step_cnt == STEP_W'(GAIN_BITS - 1);
  assign stat.fold_now = bucket_open && (div_q != open_bucket);
  assign stat.seeded   = seeded;
  assign stat.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_gain       <= RST_SLOW_GAIN;
      fast_gain       <= RST_FAST_GAIN;
      slow_period     <= RST_SLOW_PERIOD;
      persist_buckets <= RST_PERSIST_BUCKETS;
      bucket_seconds  <= RST_BUCKET_SECONDS;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SLOW_GAIN:       slow_gain       <= cfg_data[GAIN_BITS-1:0];
        CFG_FAST_GAIN:       fast_gain       <= cfg_data[GAIN_BITS-1:0];
        CFG_SLOW_PERIOD:     slow_period     <= cfg_data[PERIOD_W-1:0];
        CFG_PERSIST_BUCKETS: persist_buckets <= cfg_data[PERSIST_W-1:0];
        CFG_BUCKET_SECONDS:  bucket_seconds  <= cfg_data[SECONDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Restoring divider, one quotient bit per step; the timestamp shifts out
  // of div_q as the bucket index shifts in.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load || cmd.mul_start) begin
      step_cnt <= '0;
    end else if (cmd.div_step || cmd.mul_step) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_q    <= sample.sample_time;
      div_r    <= '0;
      div_d    <= (bucket_seconds == '0) ? SECONDS_W'(1) : bucket_seconds;
      close_in <= sample.close_price;
    end else if (cmd.div_step) begin
      div_q <= {div_q[TIME_W-2:0], div_ge};
      div_r <= div_ge ? div_trial[SECONDS_W-1:0] : div_shift[SECONDS_W-1:0];
    end
  end

  // Shared serial multiplier, gain MSB first.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_down <= cfix < sel_avg;
      mag      <= (cfix < sel_avg) ? (sel_avg - cfix) : (cfix - sel_avg);
      gain_sh  <= cmd.sel_fast ? fast_gain : slow_gain;
      acc      <= '0;
    end else if (cmd.mul_step) begin
      acc     <= {acc[ACC_W-2:0], 1'b0} + (gain_sh[GAIN_BITS-1] ? ACC_W'(mag) : '0);
      gain_sh <= {gain_sh[GAIN_BITS-2:0], 1'b0};
    end else if (cmd.mul_round && mul_down) begin
      // Round the magnitude up so a falling average floors toward minus infinity.
      acc <= acc + ROUND_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_avg <= '0;
      fast_avg <= '0;
      seeded   <= 1'b0;
    end else if (cmd.seed) begin
      slow_avg <= cfix;
      fast_avg <= cfix;
      seeded   <= 1'b1;
    end else if (cmd.mul_apply) begin
      if (cmd.sel_fast) begin
        fast_avg <= mul_down ? (fast_avg - delta) : (fast_avg + delta);
      end else begin
        slow_avg <= mul_down ? (slow_avg - delta) : (slow_avg + delta);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_write) begin
      hist_mem[hist_wp] <= slow_avg;
    end
    if (cmd.hist_read) begin
      hist_rd <= hist_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_write) begin
      rd_idx <= back_diff[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_wp      <= '0;
      hist_fill    <= '0;
      bucket_count <= '0;
      bear_flag    <= 1'b0;
      bull_flag    <= 1'b0;
    end else if (cmd.hist_write) begin
      hist_wp <= (hist_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : hist_wp + PTR_W'(1);
      if (hist_fill != FILL_W'(HISTORY_DEPTH)) begin
        hist_fill <= hist_fill + FILL_W'(1);
      end
      if (bucket_count != '1) begin
        bucket_count <= bucket_count + COUNT_W'(1);
      end
      bear_flag <= 1'b0;
      bull_flag <= 1'b0;
    end else if (cmd.eval && warm && fill_ok) begin
      priority if (cfix < slow_avg && slow_avg < hist_rd && fast_avg < slow_avg) begin
        bear_flag <= 1'b1;
      end else if (cfix > slow_avg && slow_avg > hist_rd && fast_avg > slow_avg) begin
        bull_flag <= 1'b1;
      end else begin
        bear_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_open <= 1'b0;
      closed_flag <= 1'b0;
    end else begin
      if (cmd.check) begin
        closed_flag <= stat.fold_now;
      end
      if (cmd.emit) begin
        bucket_open <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      open_bucket  <= div_q;
      bucket_close <= close_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.long_block    <= bear_flag;
      result.short_block   <= bull_flag;
      result.is_warm       <= warm;
      result.bucket_closed <= closed_flag;
    end
  end

  `HETRG_ASSERT_IMPL(a_flags_exclusive, 1'b1, !(bear_flag && bull_flag), "bear and bull flags both set")
  `HETRG_ASSERT_IMPL(a_fold_counted, cmd.emit && closed_flag, bucket_count != '0, "folded bucket left bucket count at zero")
  `HETRG_ASSERT_IMPL(a_fill_bounded, 1'b1, hist_fill <= FILL_W'(HISTORY_DEPTH), "history fill beyond depth")

endmodule
